/* hw/rtl/union_find_edge_filter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the union-find edge filter
// Short forms of clocked, reset-gated concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_EDGE_FILTER_ASSERT_SVH
`define UNION_FIND_EDGE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFEF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UFEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ufef_pkg.sv */
// ---------------------------------------------------------------------------
// ufef_pkg
// Types and constants shared by the union-find edge filter modules.
// ---------------------------------------------------------------------------
package ufef_pkg;

    // Fixed field widths of the edge and result requests.
    localparam int unsigned VERTEX_W = 10;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 11;

    // Reset value of the vertex count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Edge status codes.
    localparam logic [STATUS_W-1:0] ST_TREE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CYCLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_WALK_A,
        S_WALK_B,
        S_DONE
    } t_state;

    // Source of the parent store read address.
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_PARENT
    } t_rd_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    clr_en;
        logic    rd_en;
        t_rd_src rd_src;
        logic    cap_a;
        logic    set_range;
        logic    finish;
        logic    load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_of_range;
        logic rd_root;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/ufef_in_if.sv */
// ---------------------------------------------------------------------------
// ufef_in_if
// Edge request channel: valid/ready handshake with the edge payload.
// ---------------------------------------------------------------------------
interface ufef_in_if;

    logic                             valid;
    logic                             ready;
    logic                             new_graph;
    logic [ufef_pkg::VERTEX_W-1:0]    vertex_a;
    logic [ufef_pkg::VERTEX_W-1:0]    vertex_b;
    logic [ufef_pkg::WEIGHT_W-1:0]    edge_weight;

    modport source (
        output valid, new_graph, vertex_a, vertex_b, edge_weight,
        input  ready
    );

    modport sink (
        input  valid, new_graph, vertex_a, vertex_b, edge_weight,
        output ready
    );

endinterface

/* hw/rtl/ufef_out_if.sv */
// ---------------------------------------------------------------------------
// ufef_out_if
// Result request channel: valid/ready handshake with the edge status.
// ---------------------------------------------------------------------------
interface ufef_out_if;

    logic                             valid;
    logic                             ready;
    logic [ufef_pkg::STATUS_W-1:0]    edge_status;
    logic [ufef_pkg::VERTEX_W-1:0]    out_vertex_a;
    logic [ufef_pkg::VERTEX_W-1:0]    out_vertex_b;
    logic [ufef_pkg::WEIGHT_W-1:0]    out_weight;

    modport source (
        output valid, edge_status, out_vertex_a, out_vertex_b, out_weight,
        input  ready
    );

    modport sink (
        input  valid, edge_status, out_vertex_a, out_vertex_b, out_weight,
        output ready
    );

endinterface

/* hw/rtl/ufef_ctrl.sv */
// ---------------------------------------------------------------------------
// ufef_ctrl
// Controller state machine: sequences the clearing sweep, the two root
// walks, the link write and the hand-over to the result register.
// ---------------------------------------------------------------------------
module ufef_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_new_graph,
    output logic               o_in_ready,
    output ufef_pkg::t_dp_cmd  o_cmd,
    input  ufef_pkg::t_dp_sts  i_sts
);

    ufef_pkg::t_state r_state;
    ufef_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufef_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ufef_pkg::S_INIT: begin
                if (i_sts.clr_last) n_state = ufef_pkg::S_IDLE;
            end
            ufef_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_new_graph ? ufef_pkg::S_CLEAR : ufef_pkg::S_CHECK;
                end
            end
            ufef_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = ufef_pkg::S_CHECK;
            end
            ufef_pkg::S_CHECK: begin
                n_state = i_sts.out_of_range ? ufef_pkg::S_DONE : ufef_pkg::S_WALK_A;
            end
            ufef_pkg::S_WALK_A: begin
                if (i_sts.rd_root) n_state = ufef_pkg::S_WALK_B;
            end
            ufef_pkg::S_WALK_B: begin
                if (i_sts.rd_root) n_state = ufef_pkg::S_DONE;
            end
            ufef_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = ufef_pkg::S_IDLE;
            end
            default: begin
                n_state = ufef_pkg::S_INIT;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.rd_src    = ufef_pkg::RD_A;
        case (r_state)
            ufef_pkg::S_INIT: begin
                o_cmd.clr_en = 1'b1;
            end
            ufef_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ufef_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ufef_pkg::S_CHECK: begin
                if (i_sts.out_of_range) begin
                    o_cmd.set_range = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = ufef_pkg::RD_A;
                end
            end
            ufef_pkg::S_WALK_A: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.rd_root) begin
                    o_cmd.cap_a  = 1'b1;
                    o_cmd.rd_src = ufef_pkg::RD_B;
                end else begin
                    o_cmd.rd_src = ufef_pkg::RD_PARENT;
                end
            end
            ufef_pkg::S_WALK_B: begin
                if (i_sts.rd_root) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = ufef_pkg::RD_PARENT;
                end
            end
            ufef_pkg::S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/ufef_datapath.sv */
// ---------------------------------------------------------------------------
// ufef_datapath
// Parent store, item and walk registers, range check, link write and the
// result register.
// ---------------------------------------------------------------------------
module ufef_datapath #(
    parameter int unsigned MAX_VERTICES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ufef_pkg::COUNT_W-1:0]      i_cfg_data,
    input  ufef_pkg::t_dp_cmd                 i_cmd,
    output ufef_pkg::t_dp_sts                 o_sts,
    input  logic [ufef_pkg::VERTEX_W-1:0]     i_vertex_a,
    input  logic [ufef_pkg::VERTEX_W-1:0]     i_vertex_b,
    input  logic [ufef_pkg::WEIGHT_W-1:0]     i_edge_weight,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ufef_pkg::STATUS_W-1:0]     o_edge_status,
    output logic [ufef_pkg::VERTEX_W-1:0]     o_out_vertex_a,
    output logic [ufef_pkg::VERTEX_W-1:0]     o_out_vertex_b,
    output logic [ufef_pkg::WEIGHT_W-1:0]     o_out_weight
);

    // Store address width and the width used for the range compare.
    localparam int unsigned AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned LW  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned CW  = (LW > ufef_pkg::COUNT_W) ? LW : ufef_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0] MAX_CW   = CW'(MAX_VERTICES);

    // Each entry holds a root flag in its top bit above the parent index.
    logic [AW:0] mem [MAX_VERTICES];

    logic [ufef_pkg::COUNT_W-1:0]  r_vertex_count;
    logic [ufef_pkg::VERTEX_W-1:0] r_a;
    logic [ufef_pkg::VERTEX_W-1:0] r_b;
    logic [ufef_pkg::WEIGHT_W-1:0] r_weight;
    logic [AW-1:0]                 r_clr_idx;
    logic [AW-1:0]                 r_node;
    logic [AW-1:0]                 r_root_a;
    logic [AW:0]                   r_rd_data;
    logic [ufef_pkg::STATUS_W-1:0] r_status;
    logic                          r_out_valid;
    logic [ufef_pkg::STATUS_W-1:0] r_out_status;
    logic [ufef_pkg::VERTEX_W-1:0] r_out_a;
    logic [ufef_pkg::VERTEX_W-1:0] r_out_b;
    logic [ufef_pkg::WEIGHT_W-1:0] r_out_weight;

    logic [AW-1:0] rd_addr;
    logic          a_ok;
    logic          b_ok;
    logic          link_we;

    // Vertex count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ufef_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Latch the accepted edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_a      <= i_vertex_a;
            r_b      <= i_vertex_b;
            r_weight <= i_edge_weight;
        end
    end

    // An endpoint is in range below both the count register and the store depth.
    assign a_ok = (CW'(r_a) < CW'(r_vertex_count)) && (CW'(r_a) < MAX_CW);
    assign b_ok = (CW'(r_b) < CW'(r_vertex_count)) && (CW'(r_b) < MAX_CW);

    // Clearing sweep index, back to zero after the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_idx <= (r_clr_idx == LAST_IDX) ? '0 : r_clr_idx + 1'b1;
        end
    end

    // Read address: an endpoint, or the parent of the entry just read.
    always_comb begin
        case (i_cmd.rd_src)
            ufef_pkg::RD_A:      rd_addr = AW'(r_a);
            ufef_pkg::RD_B:      rd_addr = AW'(r_b);
            ufef_pkg::RD_PARENT: rd_addr = r_rd_data[AW-1:0];
            default:             rd_addr = AW'(r_a);
        endcase
    end

    // The root of a lies under the root of b when the two differ.
    assign link_we = i_cmd.finish && (r_root_a != r_node);

    // Parent store: one write port for the sweep or the link, one read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[r_clr_idx] <= {1'b1, {AW{1'b0}}};
        end else if (link_we) begin
            mem[r_root_a] <= {1'b0, r_node};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Walk registers: the node whose entry is being read, and the root of a.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_node <= rd_addr;
        end
        if (i_cmd.cap_a) begin
            r_root_a <= r_node;
        end
    end

    // Edge status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_range) begin
            r_status <= ufef_pkg::ST_RANGE;
        end else if (i_cmd.finish) begin
            r_status <= (r_root_a == r_node) ? ufef_pkg::ST_CYCLE : ufef_pkg::ST_TREE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_a      <= r_a;
            r_out_b      <= r_b;
            r_out_weight <= r_weight;
        end
    end

    // Status to the controller.
    assign o_sts.clr_last     = (r_clr_idx == LAST_IDX);
    assign o_sts.out_of_range = !(a_ok && b_ok);
    assign o_sts.rd_root      = r_rd_data[AW];
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_edge_status  = r_out_status;
    assign o_out_vertex_a = r_out_a;
    assign o_out_vertex_b = r_out_b;
    assign o_out_weight   = r_out_weight;

endmodule

/* hw/rtl/union_find_edge_filter.sv */
// Flow: an edge request is taken in the idle state and range-checked, then the
// parent chains of both endpoints are walked (one store read per step) and the result loaded;
// an out-of-range edge goes straight from the check to the result. The controller takes
// the next request only in its idle state, after the result is loaded; a new_graph edge
// adds a clearing sweep before the check, and a stalled result holds the block.
// Reset: a clearing sweep marks every entry as root; no edge is
// taken until it ends, and the vertex count returns to 1024.
// ---------------------------------------------------------------------------
// union_find_edge_filter
// Cycle check over a stream of weighted edges using a disjoint-set forest:
// each edge is passed on with its status (joins tree, closes cycle, or out
// of range).
// ---------------------------------------------------------------------------
`include "union_find_edge_filter_assert.svh"

module union_find_edge_filter #(
    parameter int unsigned MAX_VERTICES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ufef_pkg::COUNT_W-1:0] i_cfg_data,
    ufef_in_if.sink                      i_edge,
    ufef_out_if.source                   o_result
);

    ufef_pkg::t_dp_cmd dp_cmd;
    ufef_pkg::t_dp_sts dp_sts;
    logic              in_ready;

    assign i_edge.ready = in_ready;

    // Controller.
    ufef_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_edge.valid),
        .i_in_new_graph (i_edge.new_graph),
        .o_in_ready     (in_ready),
        .o_cmd          (dp_cmd),
        .i_sts          (dp_sts)
    );

    // Datapath with the parent store.
    ufef_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_vertex_a     (i_edge.vertex_a),
        .i_vertex_b     (i_edge.vertex_b),
        .i_edge_weight  (i_edge.edge_weight),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_edge_status  (o_result.edge_status),
        .o_out_vertex_a (o_result.out_vertex_a),
        .o_out_vertex_b (o_result.out_vertex_b),
        .o_out_weight   (o_result.out_weight)
    );

    // A result is only loaded into a free result register.
    `UFEF_ASSERT_SAME(a_load_free, i_clk, i_rst_n, dp_cmd.load_out, !o_result.valid || o_result.ready, "result overwritten before taken")
    // No edge request is taken during a clearing sweep.
    `UFEF_ASSERT_SAME(a_no_take_clear, i_clk, i_rst_n, dp_cmd.clr_en, !i_edge.ready, "edge taken during clearing")
    // A new_graph edge starts the clearing sweep.
    `UFEF_ASSERT_NEXT(a_new_graph_clr, i_clk, i_rst_n, i_edge.valid && i_edge.ready && i_edge.new_graph, dp_cmd.clr_en, "new_graph edge did not clear")
    // Loading a result makes it visible on the next cycle.
    `UFEF_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, dp_cmd.load_out, o_result.valid, "loaded result not presented")

endmodule
